// ===== hw/rtl/iar_pkg.sv =====
package iar_pkg;

	// Input word width; the low VALUE_WIDTH bits of the value port, here all 64, are converted
	localparam int VALUE_WIDTH = 64;

	// Digit slots: enough for octal, which is the longest form
	localparam int NUM_DIGITS = (VALUE_WIDTH + 2) / 3;
	localparam int DIGIT_W    = 4;
	localparam int DREG_W     = NUM_DIGITS * DIGIT_W;

	// Counter widths
	localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

	// ASCII offsets
	localparam logic [6:0] CHAR_ZERO        = 7'd48;
	localparam logic [6:0] LOWER_HEX_OFFSET = 7'd87;
	localparam logic [6:0] UPPER_HEX_OFFSET = 7'd55;
	localparam logic [6:0] DIGIT_NINE       = 7'd9;

	// Conversion modes; the unused codes convert as unsigned decimal
	localparam logic [2:0] OP_SIGNED_DEC   = 3'd0;
	localparam logic [2:0] OP_UNSIGNED_DEC = 3'd1;
	localparam logic [2:0] OP_OCTAL        = 3'd2;
	localparam logic [2:0] OP_HEX_LOWER    = 3'd3;
	localparam logic [2:0] OP_HEX_UPPER    = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_SKIP,
		ST_EMIT
	} state_t;

	// Digit value to ASCII code
	function automatic logic [6:0] to_char(input logic [DIGIT_W-1:0] d, input logic upper);
		logic [6:0] dw;
		dw = 7'(d);
		if (dw <= DIGIT_NINE) begin
			to_char = dw + CHAR_ZERO;
		end else if (upper) begin
			to_char = dw + UPPER_HEX_OFFSET;
		end else begin
			to_char = dw + LOWER_HEX_OFFSET;
		end
	endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_radix_top.sv =====
// Integer to ASCII converter. A request carries a VALUE_WIDTH-bit value and a mode
// (signed decimal, unsigned decimal, octal, lower or upper hex); the block returns
// the digits most significant first, one ASCII character per response, with
// last_digit set on the final one. Zero gives "0"; signed decimal gives the
// magnitude only. Each request is taken in the idle state; in decimal modes the
// BCD digits are then built by shift-and-add-3 through one shared correction unit,
// one value bit per step; then leading zero digit slots are dropped, and the block
// moves on to sending; then the digits are sent when the response side is ready.
// Dropped slots and sent digits always add up to NUM_DIGITS (22), and a waiting
// digit that the response side holds back stalls the sending. req_ready is low
// while a request is converted; it rises as the last digit enters the response
// register, so the next request may be taken while that digit still waits.
module integer_to_ascii_radix_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [2:0] operation,
	input  logic [63:0] value,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [6:0] digit_char,
	output logic       last_digit
);

	iar_pkg::state_t state_q, state_d;

	logic [iar_pkg::VALUE_WIDTH-1:0] bin_q;
	logic [iar_pkg::DREG_W-1:0]      dig_q;
	logic [iar_pkg::BIT_CNT_W-1:0]   bit_cnt_q;
	logic [iar_pkg::DIG_CNT_W-1:0]   dig_cnt_q;
	logic                            upper_q;
	logic                            rsp_valid_q;
	logic [6:0]                      char_q;
	logic                            last_q;

	logic                            take_req;
	logic                            do_dabble;
	logic                            do_shift;
	logic                            load_rsp;
	logic                            is_decimal;
	logic [iar_pkg::VALUE_WIDTH-1:0] mag;
	logic [iar_pkg::DREG_W-1:0]      padded;
	logic [iar_pkg::DREG_W-1:0]      oct_digits;
	logic [iar_pkg::DREG_W-1:0]      corr;
	logic [iar_pkg::DIGIT_W-1:0]     top_digit;

	// Request decode: magnitude for signed decimal, radix selection
	always_comb begin
		mag = value[iar_pkg::VALUE_WIDTH-1:0];
		if (operation == iar_pkg::OP_SIGNED_DEC && mag[iar_pkg::VALUE_WIDTH-1]) begin
			mag = ~mag + 1'b1;
		end
		is_decimal = !(operation inside {iar_pkg::OP_OCTAL, iar_pkg::OP_HEX_LOWER,
			iar_pkg::OP_HEX_UPPER});
	end

	// Octal and hex digits are plain bit groups, widened to digit slots
	always_comb begin
		padded = iar_pkg::DREG_W'(mag);
		for (int j = 0; j < iar_pkg::NUM_DIGITS; j++) begin
			oct_digits[j*iar_pkg::DIGIT_W +: iar_pkg::DIGIT_W] = {1'b0, padded[j*3 +: 3]};
		end
	end

	// Shared add-3 correction over all BCD digits
	always_comb begin
		for (int j = 0; j < iar_pkg::NUM_DIGITS; j++) begin
			if (dig_q[j*iar_pkg::DIGIT_W +: iar_pkg::DIGIT_W] >= 4'd5) begin
				corr[j*iar_pkg::DIGIT_W +: iar_pkg::DIGIT_W] =
					dig_q[j*iar_pkg::DIGIT_W +: iar_pkg::DIGIT_W] + 4'd3;
			end else begin
				corr[j*iar_pkg::DIGIT_W +: iar_pkg::DIGIT_W] =
					dig_q[j*iar_pkg::DIGIT_W +: iar_pkg::DIGIT_W];
			end
		end
	end

	assign top_digit = dig_q[iar_pkg::DREG_W-1 -: iar_pkg::DIGIT_W];

	// Sequencer: next state and step controls
	always_comb begin
		state_d   = state_q;
		take_req  = 1'b0;
		do_dabble = 1'b0;
		do_shift  = 1'b0;
		load_rsp  = 1'b0;
		req_ready = 1'b0;
		case (state_q)
			iar_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					take_req = 1'b1;
					state_d  = is_decimal ? iar_pkg::ST_DABBLE : iar_pkg::ST_SKIP;
				end
			end
			iar_pkg::ST_DABBLE: begin
				do_dabble = 1'b1;
				if (bit_cnt_q == iar_pkg::BIT_CNT_W'(1)) begin
					state_d = iar_pkg::ST_SKIP;
				end
			end
			iar_pkg::ST_SKIP: begin
				if (top_digit == '0 && dig_cnt_q > iar_pkg::DIG_CNT_W'(1)) begin
					do_shift = 1'b1;
				end else begin
					state_d = iar_pkg::ST_EMIT;
				end
			end
			iar_pkg::ST_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					do_shift = 1'b1;
					if (dig_cnt_q == iar_pkg::DIG_CNT_W'(1)) begin
						state_d = iar_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = iar_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iar_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers: binary value, digit register, counters
	always_ff @(posedge clk) begin
		if (take_req) begin
			bin_q     <= mag;
			bit_cnt_q <= iar_pkg::BIT_CNT_W'(iar_pkg::VALUE_WIDTH);
			dig_cnt_q <= iar_pkg::DIG_CNT_W'(iar_pkg::NUM_DIGITS);
			upper_q   <= (operation == iar_pkg::OP_HEX_UPPER);
			if (is_decimal) begin
				dig_q <= '0;
			end else if (operation == iar_pkg::OP_OCTAL) begin
				dig_q <= oct_digits;
			end else begin
				dig_q <= padded;
			end
		end else if (do_dabble) begin
			dig_q     <= {corr[iar_pkg::DREG_W-2:0], bin_q[iar_pkg::VALUE_WIDTH-1]};
			bin_q     <= {bin_q[iar_pkg::VALUE_WIDTH-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q - 1'b1;
		end else if (do_shift) begin
			dig_q     <= {dig_q[iar_pkg::DREG_W-iar_pkg::DIGIT_W-1:0], {iar_pkg::DIGIT_W{1'b0}}};
			dig_cnt_q <= dig_cnt_q - 1'b1;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			char_q <= iar_pkg::to_char(top_digit, upper_q);
			last_q <= (dig_cnt_q == iar_pkg::DIG_CNT_W'(1));
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

endmodule

// ===== hw/rtl/iar_checker.sv =====
module iar_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [6:0] digit_char,
	input logic       last_digit
);

	// A stalled response holds its character
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(digit_char) && $stable(last_digit))
		else $error("stalled response changed");

	// Only digits and the letters a-f or A-F come out
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (digit_char >= 7'd48 && digit_char <= 7'd57)
			|| (digit_char >= 7'd65 && digit_char <= 7'd70)
			|| (digit_char >= 7'd97 && digit_char <= 7'd102))
		else $error("response is not a digit character");

	// Busy for at least the cycle after a request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while still busy");

	// More digits follow a non-final one, so no new request yet
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last_digit |-> !req_ready)
		else $error("request taken before the last digit was sent");

endmodule

bind integer_to_ascii_radix_top iar_checker u_iar_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_ready  (req_ready),
	.rsp_valid  (rsp_valid),
	.rsp_ready  (rsp_ready),
	.digit_char (digit_char),
	.last_digit (last_digit)
);
